[hdl/chv_pkg.sv]
// Chunk header validator: shared types, header layout constants and result packing.
// No dependencies; imported by every module of the block.
package chv_pkg;

    localparam int DATA_W    = 8;
    localparam int VER_W     = 16;
    localparam int COUNT_W   = 16;
    localparam int OFFSET_W  = 20;
    localparam int CODELEN_W = 32;
    localparam int TDATA_W   = 72;

    localparam logic [VER_W-1:0]    VERSION_RESET   = 16'd1;
    localparam logic [OFFSET_W-1:0] FIXED_HEADER    = 20'd8;
    localparam logic [OFFSET_W-1:0] LEN_FIELD_BYTES = 20'd4;

    // "CMBC", byte 0 in the lowest lane
    localparam logic [3:0][DATA_W-1:0] MAGIC = {8'h43, 8'h42, 8'h4D, 8'h43};

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_MAGIC   = 2'd1,
        ST_BAD_VERSION = 2'd2,
        ST_TRUNCATED   = 2'd3
    } t_status;

    typedef struct packed {
        logic              last;
        logic              present;
        logic [DATA_W-1:0] data;
    } t_item;

    // status in the lowest bits
    typedef struct packed {
        logic [CODELEN_W-1:0] code_length;
        logic [OFFSET_W-1:0]  code_offset;
        logic [COUNT_W-1:0]   constant_count;
        t_status              status;
    } t_result;

endpackage

[hdl/chv_in_stage.sv]
// Chunk header validator: input register for the byte stream.
// Depends on chv_pkg (t_item).
module chv_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  chv_pkg::t_item i_item,
    input  logic          i_consume,
    output logic          o_valid,
    output chv_pkg::t_item o_item
);
    import chv_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[hdl/chv_parser.sv]
// Chunk header validator: header field capture, byte position counter and end-of-buffer checks.
// Depends on chv_pkg (layout constants, t_item, t_result).
module chv_parser #(
    parameter int POSITION_BITS = 34
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_fire,
    input  chv_pkg::t_item     i_item,
    output chv_pkg::t_result   o_result
);
    import chv_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int SW = ((P > CODELEN_W + 1) ? P : CODELEN_W + 1) + 1;

    logic [VER_W-1:0]     r_expected_version;
    logic [P-1:0]         r_pos, n_pos;
    logic                 r_magic_ok, n_magic_ok;
    logic [VER_W-1:0]     r_version, n_version;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [CODELEN_W-1:0] r_code, n_code;

    logic                 take;
    logic [OFFSET_W-1:0]  cstart_r;
    logic [P:0]           diff;
    logic [OFFSET_W-1:0]  cstart_n;
    logic [OFFSET_W-1:0]  lend;
    logic [SW-1:0]        need;
    logic                 short_buf;
    logic                 too_long;
    t_status              status;

    assign take     = i_fire && i_item.present && !(&r_pos);
    assign cstart_r = {1'b0, r_count, 3'b000} + FIXED_HEADER;
    assign diff     = {1'b0, r_pos} - (P+1)'(cstart_r);

    always_comb begin
        n_pos      = r_pos;
        n_magic_ok = r_magic_ok;
        n_version  = r_version;
        n_count    = r_count;
        n_code     = r_code;
        if (take) begin
            n_pos = r_pos + 1'b1;
            if (r_pos[P-1:2] == '0) begin
                if (i_item.data != MAGIC[r_pos[1:0]]) begin
                    n_magic_ok = 1'b0;
                end
            end else if (r_pos[P-1:3] == '0) begin
                case (r_pos[1:0])
                    2'd0:    n_version[7:0]  = i_item.data;
                    2'd1:    n_version[15:8] = i_item.data;
                    2'd2:    n_count[7:0]    = i_item.data;
                    default: n_count[15:8]   = i_item.data;
                endcase
            end else if (!diff[P] && diff[P-1:2] == '0) begin
                case (diff[1:0])
                    2'd0:    n_code[7:0]   = i_item.data;
                    2'd1:    n_code[15:8]  = i_item.data;
                    2'd2:    n_code[23:16] = i_item.data;
                    default: n_code[31:24] = i_item.data;
                endcase
            end
        end
    end

    // checks see the buffer including this transfer's byte
    assign cstart_n  = {1'b0, n_count, 3'b000} + FIXED_HEADER;
    assign lend      = cstart_n + LEN_FIELD_BYTES;
    assign need      = SW'(lend) + SW'(n_code);
    assign short_buf = (n_pos[P-1:3] == '0);
    assign too_long  = need > SW'(n_pos);

    always_comb begin
        if (short_buf) begin
            status = ST_TRUNCATED;
        end else if (!n_magic_ok) begin
            status = ST_BAD_MAGIC;
        end else if (n_version != r_expected_version) begin
            status = ST_BAD_VERSION;
        end else if (too_long) begin
            status = ST_TRUNCATED;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.constant_count = n_count;
            o_result.code_offset    = lend;
            o_result.code_length    = n_code;
        end else begin
            o_result.constant_count = '0;
            o_result.code_offset    = '0;
            o_result.code_length    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= VERSION_RESET;
        end else if (i_cfg_wen) begin
            r_expected_version <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last)) begin
            r_pos      <= '0;
            r_magic_ok <= 1'b1;
            r_version  <= '0;
            r_count    <= '0;
            r_code     <= '0;
        end else begin
            r_pos      <= n_pos;
            r_magic_ok <= n_magic_ok;
            r_version  <= n_version;
            r_count    <= n_count;
            r_code     <= n_code;
        end
    end

endmodule

[hdl/chv_out_stage.sv]
// Chunk header validator: result register towards the master side.
// Depends on chv_pkg (t_result, TDATA_W).
module chv_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  chv_pkg::t_result              i_result,
    output logic                          o_free,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [chv_pkg::TDATA_W-1:0]   o_data
);
    import chv_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = TDATA_W'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[hdl/bytecode_chunk_header_validator_core.sv]
// Chunk header validator top level: input register, header parser, result register.
// Depends on chv_pkg, chv_in_stage, chv_parser, chv_out_stage.
//
//  channel   | direction | tdata                                  | tuser        | tlast
//  s_axis    | in        | [7:0] data_byte                        | byte_present | end_of_buffer
//  m_axis    | out       | [1:0] status [17:2] constant_count     | -            | -
//            |           | [37:18] code_offset [69:38] code_length|              |
//  cfg       | in        | i_cfg_wdata = expected_version, written when i_cfg_wen is high
//
// One byte transfer per cycle unless a result stalls; an item with tlast waits in the
// input register until the result register is free, which then offers its result.
// Synchronous active-low reset clears the pipeline, the header state and sets
// expected_version to 1. A stalled result holds the item with tlast in the input
// register; transfers without tlast keep flowing while a result waits.
module bytecode_chunk_header_validator_core #(
    parameter int POSITION_BITS = 34
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // [7:0] data_byte
    input  logic                        i_s_axis_tuser,  // byte_present
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [chv_pkg::TDATA_W-1:0] o_m_axis_tdata,  // status, constant_count,
                                                         // code_offset, code_length, pad
    input  logic                        i_cfg_wen,
    input  logic [15:0]                 i_cfg_wdata
);
    import chv_pkg::*;

    t_item   s_item;
    t_item   in_item;
    logic    in_valid;
    logic    out_free;
    logic    consume;
    t_result result;

    assign s_item  = '{last: i_s_axis_tlast, present: i_s_axis_tuser, data: i_s_axis_tdata};
    assign consume = in_valid && (!in_item.last || out_free);

    chv_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (s_item),
        .i_consume (consume),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    chv_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (consume),
        .i_item      (in_item),
        .o_result    (result)
    );

    chv_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (consume && in_item.last),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule

[hdl/chv_checker.sv]
// Chunk header validator: port-level checker and its bind to the top level.
// Depends on chv_pkg and bytecode_chunk_header_validator_core.
module chv_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [chv_pkg::TDATA_W-1:0] o_m_axis_tdata
);
    import chv_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[71:70] == 2'b00)
        else $error("pad bits set");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_OK |-> o_m_axis_tdata[69:2] == '0)
        else $error("failed result carries header fields");

    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == ST_OK |->
            o_m_axis_tdata[37:18] == {1'b0, o_m_axis_tdata[17:2], 3'b000} + 20'd12)
        else $error("code offset does not follow constant count");

endmodule

bind bytecode_chunk_header_validator_core chv_checker u_chv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

[bench/tb_bytecode_chunk_header_validator_core.sv]
// Self-checking bench for bytecode_chunk_header_validator_core: streams chunk buffers byte by
// byte and compares each verdict with a cycle-free predictor of the header checks.
// Depends on chv_pkg and the core RTL only.
module tb_bytecode_chunk_header_validator_core;

    import chv_pkg::*;

    localparam logic [63:0] POSITION_MAX = (64'd1 << 34) - 64'd1;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          MAX_REPORTS  = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [TDATA_W-1:0] o_m_axis_tdata;
    logic        i_cfg_wen;
    logic [15:0] i_cfg_wdata;

    bytecode_chunk_header_validator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // predictor state
    logic [15:0] cfg_version;
    logic [63:0] chunk_pos;
    logic        magic_ok;
    logic [15:0] version_seen;
    logic [15:0] constants_seen;
    logic [31:0] code_bytes_seen;

    t_result     pending_verdicts[$];
    logic [7:0]  chunk_data[$];
    bit          chunk_has_byte[$];

    int          mismatch_count;
    int          sent_items;
    int          idle_cycles;
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    bit          hold_request;
    t_result     got_verdict;
    t_result     want_verdict;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic clear_chunk_state();
        chunk_pos       = '0;
        magic_ok        = 1'b1;
        version_seen    = '0;
        constants_seen  = '0;
        code_bytes_seen = '0;
    endtask

    task automatic track_chunk_byte(input logic [7:0] d, input logic present,
                                    input logic last);
        logic [63:0] cstart;
        logic [63:0] lend;
        t_result     v;
        if (present && chunk_pos < POSITION_MAX) begin
            cstart = FIXED_HEADER + 64'(constants_seen) * 64'd8;
            if (chunk_pos < 4) begin
                if (d != MAGIC[chunk_pos[1:0]]) magic_ok = 1'b0;
            end else if (chunk_pos == 4) begin
                version_seen[7:0] = d;
            end else if (chunk_pos == 5) begin
                version_seen[15:8] = d;
            end else if (chunk_pos == 6) begin
                constants_seen[7:0] = d;
            end else if (chunk_pos == 7) begin
                constants_seen[15:8] = d;
            end else if (chunk_pos >= cstart && chunk_pos < cstart + LEN_FIELD_BYTES) begin
                code_bytes_seen[(chunk_pos - cstart) * 8 +: 8] = d;
            end
            chunk_pos = chunk_pos + 1;
        end
        if (last) begin
            cstart = FIXED_HEADER + 64'(constants_seen) * 64'd8;
            lend   = cstart + LEN_FIELD_BYTES;
            v      = '0;
            if (chunk_pos < FIXED_HEADER)
                v.status = ST_TRUNCATED;
            else if (!magic_ok)
                v.status = ST_BAD_MAGIC;
            else if (version_seen != cfg_version)
                v.status = ST_BAD_VERSION;
            else if (cstart > chunk_pos || lend > chunk_pos
                     || 64'(code_bytes_seen) > chunk_pos - lend)
                v.status = ST_TRUNCATED;
            else
                v.status = ST_OK;
            if (v.status == ST_OK) begin
                v.constant_count = constants_seen;
                v.code_offset    = lend[OFFSET_W-1:0];
                v.code_length    = code_bytes_seen;
            end
            pending_verdicts.push_back(v);
            clear_chunk_state();
        end
    endtask

    task automatic send_item(input logic [7:0] d, input logic present, input logic last);
        @(negedge i_clk);
        if (tx_gaps_on && $urandom_range(0, 9) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = d;
        i_s_axis_tuser  = present;
        i_s_axis_tlast  = last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sent_items++;
        track_chunk_byte(d, present, last);
    endtask

    task automatic release_source();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_expected_version(input logic [15:0] v);
        release_source();
        wait_drained();
        @(negedge i_clk);
        i_cfg_wen   = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_wen   = 1'b0;
        cfg_version = v;
    endtask

    task automatic push_byte(input logic [7:0] d, input bit present);
        chunk_data.push_back(d);
        chunk_has_byte.push_back(present);
    endtask

    task automatic push_le(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++) push_byte(value[i*8 +: 8], 1'b1);
    endtask

    task automatic push_header(input logic [15:0] ver, input logic [15:0] count);
        for (int i = 0; i < 4; i++) push_byte(MAGIC[i], 1'b1);
        push_le(32'(ver), 2);
        push_le(32'(count), 2);
    endtask

    task automatic send_chunk();
        for (int i = 0; i < chunk_data.size(); i++)
            send_item(chunk_data[i], chunk_has_byte[i], i == chunk_data.size() - 1);
        chunk_data.delete();
        chunk_has_byte.delete();
    endtask

    task automatic build_random_chunk();
        int unsigned pick;
        int unsigned spot;
        logic [15:0] ver;
        logic [15:0] count;
        logic [31:0] body_len;
        chunk_data.delete();
        chunk_has_byte.delete();
        ver  = ($urandom_range(0, 99) < 85) ? cfg_version : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)      count = 16'($urandom_range(0, 3));
        else if (pick < 90) count = 16'($urandom_range(4, 12));
        else if (pick < 95) count = 16'hFFFF;
        else                count = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 65)      body_len = $urandom_range(0, 12);
        else if (pick < 85) body_len = $urandom_range(13, 48);
        else if (pick < 92) body_len = 32'hFFFF_FFFF;
        else                body_len = $urandom;
        push_header(ver, count);
        if (count <= 12) begin
            for (int i = 0; i < 8 * count; i++) push_byte(8'($urandom), 1'b1);
            push_le(body_len, 4);
            if (body_len <= 48)
                for (int i = 0; i < body_len; i++) push_byte(8'($urandom), 1'b1);
            else
                repeat ($urandom_range(0, 16)) push_byte(8'($urandom), 1'b1);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b1);
        end else begin
            repeat ($urandom_range(0, 40)) push_byte(8'($urandom), 1'b1);
        end
        if ($urandom_range(0, 99) < 8) begin
            spot = $urandom_range(0, 3);
            chunk_data[spot] = chunk_data[spot] ^ 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 99) < 15) begin
            spot = $urandom_range(0, chunk_data.size());
            while (chunk_data.size() > spot) begin
                void'(chunk_data.pop_back());
                void'(chunk_has_byte.pop_back());
            end
        end
        if ($urandom_range(0, 99) < 10) begin
            repeat ($urandom_range(1, 3)) begin
                spot = $urandom_range(0, chunk_data.size());
                chunk_data.insert(spot, 8'($urandom));
                chunk_has_byte.insert(spot, 1'b0);
            end
        end
        if (chunk_data.size() == 0 || $urandom_range(0, 99) < 15)
            push_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_random_chunks(input int target_items);
        int stop_at;
        stop_at = sent_items + target_items;
        while (sent_items < stop_at) begin
            build_random_chunk();
            send_chunk();
        end
    endtask

    // empty buffer, short buffer with a gap, minimal good chunk, bad magic, huge code length
    task automatic test_short_and_minimal();
        push_byte(8'h00, 1'b0);
        send_chunk();
        for (int i = 0; i < 4; i++) push_byte(MAGIC[i], 1'b1);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h01, 1'b1);
        send_chunk();
        push_header(16'd1, 16'd0);
        push_le(32'd0, 4);
        send_chunk();
        push_header(16'd1, 16'd0);
        chunk_data[3] = 8'h44;
        send_chunk();
        push_header(16'd1, 16'd0);
        push_le(32'hFFFF_FFFF, 4);
        send_chunk();
    endtask

    task automatic test_version_register();
        write_expected_version(16'hFFFF);
        push_header(16'hFFFF, 16'd1);
        push_le(32'hFFFF_FFFF, 4);
        push_le(32'h0000_0000, 4);
        push_le(32'd2, 4);
        push_le(32'h00FF, 2);
        push_byte(8'h5A, 1'b1);
        push_byte(8'hFF, 1'b0);
        send_chunk();
        write_expected_version(16'h0000);
        push_header(16'd1, 16'd0);
        push_le(32'd0, 4);
        send_chunk();
        push_header(16'd0, 16'd0);
        push_le(32'd1, 4);
        push_byte(8'h80, 1'b1);
        send_chunk();
        write_expected_version(VERSION_RESET);
    endtask

    task automatic test_random_chunks();
        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 3))
                0:       write_expected_version(16'h0000);
                1:       write_expected_version(16'hFFFF);
                2:       write_expected_version(16'h0001);
                default: write_expected_version(16'($urandom));
            endcase
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            send_random_chunks(200);
        end
    endtask

    // results pile up while the sink holds off; input must back-pressure
    task automatic test_output_hold();
        tx_gaps_on   = 1'b0;
        rx_gaps_on   = 1'b0;
        hold_request = 1'b1;
        repeat (8) begin
            build_random_chunk();
            send_chunk();
        end
    endtask

    task automatic test_back_to_back();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        write_expected_version(16'($urandom));
        send_random_chunks(300);
    endtask

    always begin
        @(negedge i_clk);
        if (!i_rst_n) begin
            i_m_axis_tready = 1'b0;
        end else if (hold_request) begin
            hold_request    = 1'b0;
            i_m_axis_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            i_m_axis_tready = 1'b1;
        end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
            i_m_axis_tready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
            i_m_axis_tready = 1'b1;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_verdict = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transfer: tdata %h", o_m_axis_tdata);
            end else begin
                want_verdict = pending_verdicts.pop_front();
                if (got_verdict.status != want_verdict.status
                    || got_verdict.constant_count != want_verdict.constant_count
                    || got_verdict.code_offset != want_verdict.code_offset
                    || got_verdict.code_length != want_verdict.code_length) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("verdict mismatch: exp %s/%0d/%0d/%0d got %s/%0d/%0d/%0d",
                                 want_verdict.status.name(), want_verdict.constant_count,
                                 want_verdict.code_offset, want_verdict.code_length,
                                 got_verdict.status.name(), got_verdict.constant_count,
                                 got_verdict.code_offset, got_verdict.code_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_wen       = 1'b0;
        i_cfg_wdata     = '0;
        cfg_version     = VERSION_RESET;
        mismatch_count  = 0;
        sent_items      = 0;
        idle_cycles     = 0;
        tx_gaps_on      = 1'b1;
        rx_gaps_on      = 1'b1;
        hold_request    = 1'b0;
        clear_chunk_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_and_minimal();
        test_version_register();
        test_random_chunks();
        test_output_hold();
        test_back_to_back();

        release_source();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
